// ===== hdl/pct_pkg.sv =====
// shared types, constants and character functions for the percent encoder/decoder
package pct_pkg;

    // command queue between front and back
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // characters
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UF      = 8'h46;
    localparam logic [7:0] CH_UZ      = 8'h5a;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LF      = 8'h66;
    localparam logic [7:0] CH_LZ      = 8'h7a;
    localparam logic [7:0] CH_DASH    = 8'h2d;
    localparam logic [7:0] CH_UNDER   = 8'h5f;
    localparam logic [7:0] CH_DOT     = 8'h2e;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_TILDE   = 8'h7e;
    localparam logic [7:0] CH_STAR    = 8'h2a;
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] NUL        = 8'h00;
    localparam logic [3:0] NIBBLE_TEN = 4'd10;

    // direction register values
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // what the back end does with one queued command
    typedef enum logic [1:0] {
        CMD_BYTE   = 2'd0,   // one result carrying the byte
        CMD_ESCAPE = 2'd1,   // three results: '%' and two hex digits
        CMD_END    = 2'd2    // bare end marker
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
        logic       last;
    } cmd_t;

    // push side of the queue
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } push_t;

    // head of the queue
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } head_t;

    // value of a hex digit, zero for anything else
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            d = c - CH_ZERO;
        end
        else if (c >= CH_UA && c <= CH_UF)
        begin
            d = c - CH_UA + 8'(NIBBLE_TEN);
        end
        else if (c >= CH_LA && c <= CH_LF)
        begin
            d = c - CH_LA + 8'(NIBBLE_TEN);
        end
        return d[3:0];
    endfunction

    // upper-case hex digit for a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] r;
        if (v < NIBBLE_TEN)
        begin
            r = CH_ZERO + {4'h0, v};
        end
        else
        begin
            r = CH_UA + {4'h0, v - NIBBLE_TEN};
        end
        return r;
    endfunction

    // unreserved characters that pass through encoding unchanged
    function automatic logic passes(input logic [7:0] c);
        logic p;
        p = ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ))
            || ((c >= CH_ZERO) && (c <= CH_NINE));
        case (c) inside
            CH_DASH, CH_UNDER, CH_DOT, CH_BANG, CH_TILDE,
            CH_STAR, CH_QUOTE, CH_LPAREN, CH_RPAREN, CH_SLASH:
                p = 1'b1;
            default:
                p = p;
        endcase
        return p;
    endfunction

endpackage

// ===== hdl/percent_encode_decode.sv =====
// top level of the streaming percent encoder/decoder
//
// Input channel in_valid/in_ready carries one string byte (in_byte) and a
// flag on the string's last byte (in_last). The result channel
// result_valid/result_ready carries out_byte, out_valid (0 on a bare end
// marker), run_last (last result of one input item) and string_end (last
// result of the string). The config channel cfg_valid/cfg_ready writes the
// direction bit: 0 encode, 1 decode; it is always ready.
// A front stage classifies each item and keeps the decode state, a
// four-entry command queue decouples it from the back stage, which
// emits one result per cycle from its output register unless stalled.
// The first result of an item passes through the command queue and the
// back stage's output register. Throughput: one item per cycle for
// single results unless stalled; an escape when encoding ('%' plus two
// hex digits) gives three results, emitted one per cycle.
// Reset clears direction to encode, the decode state and the queue.
// When the receiver stalls, the output holds, the queue fills and in_ready
// drops once it is full.
module percent_encode_decode (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       direction,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] out_byte,
    output logic       out_valid,
    output logic       run_last,
    output logic       string_end
);

    pct_pkg::push_t push;
    pct_pkg::head_t head;
    logic           q_full;
    logic           pop;

    pct_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .direction (direction),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .q_full    (q_full),
        .push      (push)
    );

    pct_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .pop   (pop),
        .head  (head)
    );

    pct_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_byte     (out_byte),
        .out_valid    (out_valid),
        .run_last     (run_last),
        .string_end   (string_end)
    );

endmodule

// ===== hdl/pct_front.sv =====
// front end: direction register, decode state and classification of each input item
module pct_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             direction,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    input  logic             q_full,
    output pct_pkg::push_t   push
);

    typedef enum logic [2:0] {
        ESC_IDLE  = 3'b001,
        ESC_PCT   = 3'b010,
        ESC_DIGIT = 3'b100
    } esc_state_t;

    logic       direction_reg;
    esc_state_t esc_reg, esc_next;
    logic [3:0] high_nibble_reg, high_nibble_next;
    logic       stopped_reg, stopped_next;
    logic       accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;

    // direction register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= pct_pkg::DIR_ENCODE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            direction_reg <= direction;
        end
    end

    // classify the item and work out the next decode state
    always_comb
    begin
        esc_next         = esc_reg;
        high_nibble_next = high_nibble_reg;
        stopped_next     = stopped_reg;
        push.valid       = 1'b0;
        push.cmd.kind    = pct_pkg::CMD_BYTE;
        push.cmd.data    = in_byte;
        push.cmd.last    = in_last;

        if (direction_reg == pct_pkg::DIR_ENCODE)
        begin
            push.valid    = 1'b1;
            push.cmd.kind = pct_pkg::passes(in_byte) ? pct_pkg::CMD_BYTE
                                                     : pct_pkg::CMD_ESCAPE;
        end
        else if (!stopped_reg)
        begin
            if (in_byte == pct_pkg::NUL)
            begin
                stopped_next = 1'b1;
                esc_next     = ESC_IDLE;
            end
            else
            begin
                unique case (esc_reg)
                    ESC_PCT:
                    begin
                        high_nibble_next = pct_pkg::hex_value(in_byte);
                        esc_next         = ESC_DIGIT;
                    end
                    ESC_DIGIT:
                    begin
                        push.valid    = 1'b1;
                        push.cmd.data = {high_nibble_reg, pct_pkg::hex_value(in_byte)};
                        esc_next      = ESC_IDLE;
                    end
                    default:
                    begin
                        if (in_byte == pct_pkg::CH_PERCENT)
                        begin
                            esc_next = ESC_PCT;
                        end
                        else
                        begin
                            push.valid = 1'b1;
                            esc_next   = ESC_IDLE;
                        end
                    end
                endcase
            end
        end

        // end of string: at least one result (bare marker if none), decode state clears
        if (in_last)
        begin
            if (!push.valid)
            begin
                push.valid    = 1'b1;
                push.cmd.kind = pct_pkg::CMD_END;
                push.cmd.data = pct_pkg::NUL;
            end
            esc_next         = ESC_IDLE;
            high_nibble_next = 4'h0;
            stopped_next     = 1'b0;
        end

        push.valid = push.valid && accept;
    end

    // decode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg         <= ESC_IDLE;
            high_nibble_reg <= 4'h0;
            stopped_reg     <= 1'b0;
        end
        else if (accept)
        begin
            esc_reg         <= esc_next;
            high_nibble_reg <= high_nibble_next;
            stopped_reg     <= stopped_next;
        end
    end

endmodule

// ===== hdl/pct_fifo.sv =====
// short command queue between front and back
module pct_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  pct_pkg::push_t push,
    output logic           full,
    input  logic           pop,
    output pct_pkg::head_t head
);

    pct_pkg::cmd_t                 mem_reg [pct_pkg::FIFO_DEPTH];
    logic [pct_pkg::FIFO_AW-1:0]   wr_ptr_reg;
    logic [pct_pkg::FIFO_AW-1:0]   rd_ptr_reg;
    logic [pct_pkg::FIFO_CW-1:0]   count_reg, count_next;
    logic                          do_pop;

    assign full       = (count_reg == pct_pkg::FIFO_CW'(pct_pkg::FIFO_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push.valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

// ===== hdl/pct_back.sv =====
// back end: expands queued commands into result items through an output register
module pct_back (
    input  logic           clk,
    input  logic           rst_n,
    input  pct_pkg::head_t head,
    output logic           pop,
    output logic           result_valid,
    input  logic           result_ready,
    output logic [7:0]     out_byte,
    output logic           out_valid,
    output logic           run_last,
    output logic           string_end
);

    logic       rvalid_reg;
    logic [1:0] step_reg, step_next;
    logic [7:0] byte_reg, byte_next;
    logic       ovalid_reg, ovalid_next;
    logic       run_last_reg, run_last_next;
    logic       str_end_reg, str_end_next;
    logic       load;
    logic       final_res;

    assign load      = !rvalid_reg || result_ready;
    assign final_res = (head.cmd.kind != pct_pkg::CMD_ESCAPE) || (step_reg == 2'd2);
    assign pop       = load && head.valid && final_res;

    // result for the current step of the head command
    always_comb
    begin
        ovalid_next   = 1'b1;
        run_last_next = final_res;
        str_end_next  = final_res && head.cmd.last;
        step_next     = final_res ? 2'd0 : step_reg + 2'd1;
        byte_next     = head.cmd.data;
        unique case (head.cmd.kind)
            pct_pkg::CMD_ESCAPE:
            begin
                case (step_reg)
                    2'd0:    byte_next = pct_pkg::CH_PERCENT;
                    2'd1:    byte_next = pct_pkg::hex_char(head.cmd.data[7:4]);
                    default: byte_next = pct_pkg::hex_char(head.cmd.data[3:0]);
                endcase
            end
            pct_pkg::CMD_END:
            begin
                byte_next   = pct_pkg::NUL;
                ovalid_next = 1'b0;
            end
            default:
            begin
                byte_next = head.cmd.data;
            end
        endcase
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvalid_reg <= 1'b0;
            step_reg   <= 2'd0;
        end
        else if (load)
        begin
            rvalid_reg <= head.valid;
            if (head.valid)
            begin
                step_reg <= step_next;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load && head.valid)
        begin
            byte_reg     <= byte_next;
            ovalid_reg   <= ovalid_next;
            run_last_reg <= run_last_next;
            str_end_reg  <= str_end_next;
        end
    end

    assign result_valid = rvalid_reg;
    assign out_byte     = byte_reg;
    assign out_valid    = ovalid_reg;
    assign run_last     = run_last_reg;
    assign string_end   = str_end_reg;

endmodule

// ===== hdl/pct_checker.sv =====
// port-level checks for the percent encoder/decoder, bound to the top level
module pct_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       result_valid,
    input logic       result_ready,
    input logic [7:0] out_byte,
    input logic       out_valid,
    input logic       run_last,
    input logic       string_end
);

    // a stalled item stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result item dropped while stalled");

    // end of string is always the last result of its input item
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && string_end |-> run_last)
        else $error("string_end without run_last");

    // a bare marker only closes a string
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !out_valid |-> string_end && run_last)
        else $error("bare marker not at end of string");

    // a bare marker carries a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !out_valid |-> out_byte == 8'h00)
        else $error("bare marker with nonzero byte");

endmodule

bind percent_encode_decode pct_checker u_pct_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_byte     (out_byte),
    .out_valid    (out_valid),
    .run_last     (run_last),
    .string_end   (string_end)
);

// ===== tb/tb_percent_encode_decode.sv =====
// self-checking testbench for the streaming percent encoder/decoder
module tb_percent_encode_decode;

    // one result item as seen on the output channel
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       run_end;
        logic       str_end;
    } out_item_t;

    // decode progress through a '%' escape
    typedef enum logic [2:0] {
        ESC_IDLE = 3'b001,
        ESC_HIGH = 3'b010,
        ESC_LOW  = 3'b100
    } esc_state_t;

    // predicts the result items of each accepted input item and checks them in order
    class pct_scoreboard;
        logic       dir;
        esc_state_t esc;
        logic [3:0] high_digit;
        logic       halted;
        out_item_t  queued_results[$];
        int         errors;

        function new();
            dir        = pct_pkg::DIR_ENCODE;
            esc        = ESC_IDLE;
            high_digit = 4'h0;
            halted     = 1'b0;
            errors     = 0;
        endfunction

        function void set_direction(logic d);
            dir = d;
        endfunction

        function int pending();
            return queued_results.size();
        endfunction

        // value of a hex digit in either case, zero otherwise
        function logic [3:0] digit_value(logic [7:0] c);
            logic [7:0] v;
            v = 8'h00;
            if (c inside {[pct_pkg::CH_ZERO:pct_pkg::CH_NINE]})
            begin
                v = c - pct_pkg::CH_ZERO;
            end
            else if (c inside {[pct_pkg::CH_UA:pct_pkg::CH_UF]})
            begin
                v = c - pct_pkg::CH_UA + 8'd10;
            end
            else if (c inside {[pct_pkg::CH_LA:pct_pkg::CH_LF]})
            begin
                v = c - pct_pkg::CH_LA + 8'd10;
            end
            return v[3:0];
        endfunction

        function logic [7:0] upper_hex(logic [3:0] v);
            if (v < 4'd10)
            begin
                return pct_pkg::CH_ZERO + {4'h0, v};
            end
            return pct_pkg::CH_UA + {4'h0, v} - 8'd10;
        endfunction

        function logic is_unreserved(logic [7:0] c);
            return c inside {[pct_pkg::CH_LA:pct_pkg::CH_LZ],
                             [pct_pkg::CH_UA:pct_pkg::CH_UZ],
                             [pct_pkg::CH_ZERO:pct_pkg::CH_NINE],
                             pct_pkg::CH_DASH, pct_pkg::CH_UNDER, pct_pkg::CH_DOT,
                             pct_pkg::CH_BANG, pct_pkg::CH_TILDE, pct_pkg::CH_STAR,
                             pct_pkg::CH_QUOTE, pct_pkg::CH_LPAREN, pct_pkg::CH_RPAREN,
                             pct_pkg::CH_SLASH};
        endfunction

        // work out the results of one accepted input item
        function void accept_byte(logic [7:0] b, logic last);
            out_item_t outs[3];
            int        n;
            n = 0;
            if (dir == pct_pkg::DIR_ENCODE)
            begin
                if (is_unreserved(b))
                begin
                    outs[n] = '{b, 1'b1, 1'b0, 1'b0};
                    n++;
                end
                else
                begin
                    outs[0] = '{pct_pkg::CH_PERCENT, 1'b1, 1'b0, 1'b0};
                    outs[1] = '{upper_hex(b[7:4]), 1'b1, 1'b0, 1'b0};
                    outs[2] = '{upper_hex(b[3:0]), 1'b1, 1'b0, 1'b0};
                    n = 3;
                end
            end
            else if (!halted)
            begin
                // a zero byte stops decoding until the end of the string
                if (b == pct_pkg::NUL)
                begin
                    halted = 1'b1;
                    esc    = ESC_IDLE;
                end
                else if (esc == ESC_HIGH)
                begin
                    high_digit = digit_value(b);
                    esc        = ESC_LOW;
                end
                else if (esc == ESC_LOW)
                begin
                    outs[n] = '{{high_digit, digit_value(b)}, 1'b1, 1'b0, 1'b0};
                    n++;
                    esc = ESC_IDLE;
                end
                else if (b == pct_pkg::CH_PERCENT)
                begin
                    esc = ESC_HIGH;
                end
                else
                begin
                    outs[n] = '{b, 1'b1, 1'b0, 1'b0};
                    n++;
                end
            end

            // end of string: bare marker if nothing else came, then clear decode state
            if (last)
            begin
                if (n == 0)
                begin
                    outs[n] = '{8'h00, 1'b0, 1'b0, 1'b0};
                    n++;
                end
                outs[n-1].str_end = 1'b1;
                esc        = ESC_IDLE;
                high_digit = 4'h0;
                halted     = 1'b0;
            end
            if (n > 0)
            begin
                outs[n-1].run_end = 1'b1;
            end
            for (int k = 0; k < n; k++)
            begin
                queued_results.push_back(outs[k]);
            end
        endfunction

        // compare one accepted result item with the oldest prediction
        function void check_result(logic [7:0] data, logic has_byte, logic run_end,
                                   logic str_end);
            out_item_t want;
            if (queued_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result item, expected none, got byte %02h valid %0b",
                         $time, data, has_byte);
                return;
            end
            want = queued_results.pop_front();
            if (data !== want.data)
            begin
                errors++;
                $display("%0t: out_byte expected %02h, got %02h", $time, want.data, data);
            end
            if (has_byte !== want.has_byte)
            begin
                errors++;
                $display("%0t: out_valid expected %0b, got %0b", $time, want.has_byte,
                         has_byte);
            end
            if (run_end !== want.run_end)
            begin
                errors++;
                $display("%0t: run_last expected %0b, got %0b", $time, want.run_end, run_end);
            end
            if (str_end !== want.str_end)
            begin
                errors++;
                $display("%0t: string_end expected %0b, got %0b", $time, want.str_end,
                         str_end);
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_dir = pct_pkg::DIR_ENCODE;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = 8'h00;
    logic       in_last = 1'b0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       run_last;
    logic       string_end;

    int            send_idle_pct = 33;
    int            recv_idle_pct = 45;
    bit            hold_req = 1'b0;
    pct_scoreboard sb = new();

    percent_encode_decode DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .direction    (cfg_dir),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_byte     (out_byte),
        .out_valid    (out_valid),
        .run_last     (run_last),
        .string_end   (string_end)
    );

    always #2 clk = ~clk;

    // offer one input item and hold it until accepted
    task automatic send_item(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= last;
        @(negedge clk);
        while (!in_ready)
        begin
            @(negedge clk);
        end
        sb.accept_byte(b, last);
        @(posedge clk);
    endtask

    task automatic write_direction(input logic d);
        cfg_valid <= 1'b1;
        cfg_dir   <= d;
        @(negedge clk);
        while (!cfg_ready)
        begin
            @(negedge clk);
        end
        sb.set_direction(d);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // let every predicted result arrive, then wait on for silent items
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_hex_digit();
        int pick;
        pick = $urandom_range(2);
        if (pick == 0)
        begin
            return pct_pkg::CH_ZERO + 8'($urandom_range(9));
        end
        else if (pick == 1)
        begin
            return pct_pkg::CH_UA + 8'($urandom_range(5));
        end
        return pct_pkg::CH_LA + 8'($urandom_range(5));
    endfunction

    // one random string; decode strings are mostly escapes and literals, cut at random
    task automatic send_random_string(input logic dec, output int count);
        logic [7:0] str[$];
        int         target;
        int         pick;
        target = $urandom_range(1, 10);
        while (str.size() < target)
        begin
            pick = $urandom_range(99);
            if (!dec)
            begin
                if (pick < 50)
                begin
                    str.push_back(8'($urandom_range(8'h20, 8'h7e)));
                end
                else
                begin
                    str.push_back(8'($urandom_range(255)));
                end
            end
            else if (pick < 45)
            begin
                str.push_back(pct_pkg::CH_PERCENT);
                str.push_back(rand_hex_digit());
                str.push_back(rand_hex_digit());
            end
            else if (pick < 55)
            begin
                str.push_back(pct_pkg::CH_PERCENT);
                str.push_back(8'($urandom_range(255)));
                str.push_back(8'($urandom_range(255)));
            end
            else if (pick < 60)
            begin
                str.push_back(pct_pkg::NUL);
            end
            else
            begin
                str.push_back(8'($urandom_range(1, 255)));
            end
        end
        while (str.size() > target)
        begin
            void'(str.pop_back());
        end
        for (int k = 0; k < str.size(); k++)
        begin
            send_item(str[k], k == str.size() - 1);
        end
        count = str.size();
    endtask

    // result side: random stalls, one long hold-off on request, check at mid-cycle
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = 80;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
            @(negedge clk);
            if (rst_n && result_valid && result_ready)
            begin
                sb.check_result(out_byte, out_valid, run_last, string_end);
            end
        end
    end

    // stimulus
    initial
    begin
        int seg_items;
        int n;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_direction(pct_pkg::DIR_ENCODE);

        // encode: zero byte, top byte, pass-through marks, escaped space
        send_item(pct_pkg::NUL, 1'b0);
        send_item(8'hff, 1'b0);
        send_item(pct_pkg::CH_LZ, 1'b0);
        send_item(pct_pkg::CH_TILDE, 1'b0);
        send_item(8'h20, 1'b0);
        send_item(pct_pkg::CH_SLASH, 1'b1);
        wait_idle();
        write_direction(pct_pkg::DIR_DECODE);

        // decode: full escape, non-hex digits, literal, escape cut by end of string
        send_item(pct_pkg::CH_PERCENT, 1'b0);
        send_item(pct_pkg::CH_LF, 1'b0);
        send_item(pct_pkg::CH_UF, 1'b0);
        send_item(pct_pkg::CH_PERCENT, 1'b0);
        send_item(8'h47, 1'b0);
        send_item(pct_pkg::CH_PERCENT, 1'b0);
        send_item(8'h51, 1'b0);
        send_item(pct_pkg::CH_PERCENT, 1'b0);
        send_item(8'h34, 1'b1);
        // zero byte drops the pending escape and silences the rest of the string
        send_item(pct_pkg::CH_PERCENT, 1'b0);
        send_item(pct_pkg::NUL, 1'b0);
        send_item(pct_pkg::CH_LA, 1'b0);
        send_item(8'hff, 1'b1);
        send_item(8'h42, 1'b1);
        // switch direction in the middle of an escape, then resume decoding
        send_item(pct_pkg::CH_PERCENT, 1'b0);
        send_item(8'h34, 1'b0);
        wait_idle();
        write_direction(pct_pkg::DIR_ENCODE);
        send_item(pct_pkg::CH_UA, 1'b0);
        wait_idle();
        write_direction(pct_pkg::DIR_DECODE);
        send_item(8'h31, 1'b1);

        // random strings in three idle regimes, four direction segments each
        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                send_idle_pct = 45;
                recv_idle_pct = 33;
            end
            else if (phase == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int seg = 0; seg < 4; seg++)
            begin
                wait_idle();
                write_direction(logic'(seg[0] ^ phase[0]));
                // long result stall while the input keeps coming
                if (phase == 2 && seg == 0)
                begin
                    hold_req = 1'b1;
                end
                seg_items = 0;
                while (seg_items < 19)
                begin
                    send_random_string(sb.dir, n);
                    seg_items += n;
                end
            end
        end

        wait_idle();
        if (sb.errors == 0)
        begin
            $display("percent_encode_decode test passed");
        end
        else
        begin
            $display("percent_encode_decode test failed");
        end
        $finish;
    end

    // run limit
    initial
    begin
        #200000;
        $display("percent_encode_decode test failed");
        $finish;
    end

endmodule
